// ===== src/lrp_pkg.sv =====
// Constants and types shared by the 64-bit to 51-bit limb repacker.
// No dependencies; imported by limb_repack_64_to_51.
`timescale 1ns / 1ps
`default_nettype none

package lrp_pkg;

	localparam int WORD_BITS   = 64;
	localparam int DIGIT_BITS  = 51;
	// Digits produced per number are clamped to this value.
	localparam int MAX_DIGITS  = 16;
	// Register reset value for the digit count.
	localparam int COUNT_RESET = 15;

	localparam int CFG_W   = 5;
	// Leftover bits between words never exceed DIGIT_BITS - 1.
	localparam int PEND_W  = DIGIT_BITS - 1;
	// After one digit is cut from a merged word, at most this many bits remain.
	localparam int RES_W   = PEND_W + WORD_BITS - DIGIT_BITS;
	localparam int MERGE_W = PEND_W + WORD_BITS;
	localparam int CNT_W   = $clog2(RES_W + 1);
	localparam int SENT_W  = $clog2(MAX_DIGITS + 1);
	localparam int TDATA_IN_W  = ((WORD_BITS + 7) / 8) * 8;
	localparam int TDATA_OUT_W = ((DIGIT_BITS + 7) / 8) * 8;

	typedef logic [WORD_BITS-1:0]  word_t;
	typedef logic [DIGIT_BITS-1:0] digit_t;
	typedef logic [RES_W-1:0]      res_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [SENT_W-1:0]     sent_t;
	typedef logic [CFG_W-1:0]      cfg_t;

endpackage

`default_nettype wire

// ===== src/limb_repack_64_to_51.sv =====
// Radix 2^64 to radix 2^51 limb repacker: 64-bit words in, 51-bit digits out.
// Depends on lrp_pkg for widths, constants and types.
// The first digit of an item passes the item register and then the output register.
// Throughput: one digit per cycle while the receiver takes them, set by the single digit output
// register. A word releases one or two digits, all digits still owed on the last word, or none.
// Reset (arst_n low, asynchronous): the digit count returns to 15 and all number state clears.
`timescale 1ns / 1ps
`default_nettype none

module limb_repack_64_to_51 (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration: digit count per number.
	input  wire logic                            cfg_we,
	input  wire lrp_pkg::cfg_t                   cfg_wdata,
	// Input stream of words.
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [lrp_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // [63:0] word
	input  wire logic                            s_axis_tlast,  // word_last
	// Output stream of digits.
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [lrp_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,  // [50:0] digit, rest zero
	output logic                                 m_axis_tlast   // digit_last
);
	import lrp_pkg::*;

	// Configuration register.
	cfg_t   count_q;
	sent_t  count_eff;

	// Item register: the word being worked on and whether it has been merged
	// with the leftover bits of the previous word yet.
	logic   valid_s1;
	word_t  word_s1;
	logic   last_s1;
	logic   merged_s1;

	// Number state: the bit reservoir, its fill level and the digits sent so far.
	res_t   res_q;
	cnt_t   cnt_q;
	sent_t  sent_q;

	// Output register.
	logic   out_v_q;
	digit_t out_digit_q;
	logic   out_last_q;

	// Step logic.
	logic [MERGE_W-1:0] shifted_w;
	logic [MERGE_W-1:0] merged_w;
	digit_t digit_d;
	res_t   res_e, res_n, res_f;
	cnt_t   cnt_e, cnt_n, cnt_f;
	sent_t  sent_e, sent_n, sent_f;
	logic   has_room;
	logic   emit;
	logic   full;
	logic   done;
	logic   out_last_d;
	logic   out_free;
	logic   adv;
	logic   in_take;

	// A count of zero acts as one, and anything above the maximum is clamped.
	always_comb begin
		if (count_q == '0) begin
			count_eff = SENT_W'(1);
		end else if (int'(count_q) > MAX_DIGITS) begin
			count_eff = SENT_W'(MAX_DIGITS);
		end else begin
			count_eff = SENT_W'(count_q);
		end
	end

	// The first step of a word shifts it above the leftover bits and cuts the low digit
	// off the merged value. Later steps of the same word cut further digits from the
	// reservoir; once it holds fewer than a digit's bits, the rest of the flush on the last
	// word sends what remains and then zeros.
	always_comb begin
		shifted_w = {{(MERGE_W - WORD_BITS){1'b0}}, word_s1} << cnt_q;
		merged_w  = shifted_w | {{(MERGE_W - PEND_W){1'b0}}, res_q[PEND_W-1:0]};

		if (!merged_s1) begin
			digit_d = merged_w[DIGIT_BITS-1:0];
			res_e   = merged_w[MERGE_W-1:DIGIT_BITS];
			cnt_e   = cnt_q + CNT_W'(WORD_BITS - DIGIT_BITS);
		end else begin
			digit_d = res_q[DIGIT_BITS-1:0];
			if (int'(cnt_q) >= DIGIT_BITS) begin
				res_e = {{DIGIT_BITS{1'b0}}, res_q[RES_W-1:DIGIT_BITS]};
				cnt_e = cnt_q - CNT_W'(DIGIT_BITS);
			end else begin
				res_e = '0;
				cnt_e = '0;
			end
		end
		sent_e = sent_q + SENT_W'(1);

		has_room = (sent_q < count_eff);
		emit     = valid_s1 && has_room;

		// Once the count is met, the word adds nothing and the state holds.
		if (emit) begin
			res_n  = res_e;
			cnt_n  = cnt_e;
			sent_n = sent_e;
		end else begin
			res_n  = res_q;
			cnt_n  = cnt_q;
			sent_n = sent_q;
		end

		full = (sent_n >= count_eff);
		done = full || (!last_s1 && (int'(cnt_n) < DIGIT_BITS));

		// The last word ends the number; reaching the count with a whole digit's worth of
		// bits still held drops those bits.
		if (full && last_s1) begin
			res_f  = '0;
			cnt_f  = '0;
			sent_f = '0;
		end else if (full && (int'(cnt_n) >= DIGIT_BITS)) begin
			res_f  = '0;
			cnt_f  = '0;
			sent_f = sent_n;
		end else begin
			res_f  = res_n;
			cnt_f  = cnt_n;
			sent_f = sent_n;
		end

		out_last_d = (sent_e == count_eff);
	end

	// The output register frees up in the same cycle its digit is taken, so the step
	// stalls only when a digit is due and the previous one is still waiting.
	assign out_free      = !out_v_q || m_axis_tready;
	assign adv           = valid_s1 && (!emit || out_free);
	assign s_axis_tready = !valid_s1 || (adv && done);
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CFG_W'(COUNT_RESET);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			merged_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1  <= 1'b1;
			merged_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1  <= !done;
			merged_s1 <= !done;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= s_axis_tdata[WORD_BITS-1:0];
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q  <= '0;
			cnt_q  <= '0;
			sent_q <= '0;
		end else if (adv) begin
			res_q  <= res_f;
			cnt_q  <= cnt_f;
			sent_q <= sent_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && emit) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_digit_q <= digit_d;
			out_last_q  <= out_last_d;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {{(TDATA_OUT_W - DIGIT_BITS){1'b0}}, out_digit_q};
	assign m_axis_tlast  = out_last_q;

	// Between words, the reservoir holds less than one digit's worth of bits.
	a_cnt_between_words: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !merged_s1) |-> (int'(cnt_q) < DIGIT_BITS))
		else $error("bit count too large between words");

	// With less than a digit's worth held, the reservoir bits above the leftover field are always clear.
	a_res_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cnt_q) < DIGIT_BITS) |-> (res_q[RES_W-1:PEND_W] == '0))
		else $error("stale bits above pending data");

	// The final digit of a number always finishes the word that produced it.
	a_last_digit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit && out_last_d) |-> done)
		else $error("word continues after its final digit");

endmodule

`default_nettype wire

// ===== verif/lrp_digit_checker.sv =====
// Digit checker for the 64-bit to 51-bit limb repacker: watches the word, digit and
// configuration channels, predicts every digit and compares. Depends on lrp_pkg.
`timescale 1ns / 1ps

module lrp_digit_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire lrp_pkg::cfg_t                   cfg_wdata,
	input  wire logic                            s_axis_tvalid,
	input  wire logic                            s_axis_tready,
	input  wire logic [lrp_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // [63:0] word
	input  wire logic                            s_axis_tlast,  // word_last
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic [lrp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // [50:0] digit, rest zero
	input  wire logic                            m_axis_tlast,  // digit_last
	output int                                   fail_count,
	output int                                   digits_owed,
	output int                                   digits_checked
);
	import lrp_pkg::*;

	typedef struct packed {
		digit_t digit;
		logic   last;
	} owed_digit_t;

	owed_digit_t        owed_q[$];
	cfg_t               count_reg;
	logic [PEND_W-1:0]  carry_bits;
	int unsigned        carry_len;
	int unsigned        sent_cnt;
	int                 mismatches;

	function automatic int unsigned digits_per_number(input cfg_t c);
		if (c == '0) begin
			return 1;
		end
		if (c > MAX_DIGITS) begin
			return MAX_DIGITS;
		end
		return c;
	endfunction

	task automatic owe_digit(input digit_t d, input int unsigned lim);
		sent_cnt++;
		owed_q.push_back('{digit: d, last: (sent_cnt == lim)});
	endtask

	// Merges one word with the carried bits and cuts off as many digits as the count allows.
	task automatic repack_word(input word_t w, input logic last);
		logic [WORD_BITS-1:0] lo;
		logic [WORD_BITS-1:0] hi;
		logic [WORD_BITS-1:0] mask;
		int unsigned          n;
		int unsigned          lim;
		lim = digits_per_number(count_reg);
		if (sent_cnt < lim) begin
			if (carry_len == 0) begin
				lo = w;
				hi = '0;
			end else begin
				lo = {{(WORD_BITS-PEND_W){1'b0}}, carry_bits} | (w << carry_len);
				hi = w >> (WORD_BITS - carry_len);
			end
			n = carry_len + WORD_BITS;
			while (n >= DIGIT_BITS && sent_cnt < lim) begin
				owe_digit(lo[DIGIT_BITS-1:0], lim);
				lo = (lo >> DIGIT_BITS) | (hi << (WORD_BITS - DIGIT_BITS));
				hi = hi >> DIGIT_BITS;
				n -= DIGIT_BITS;
			end
			// The count ran out with a full digit still held: those bits are lost.
			if (n >= DIGIT_BITS) begin
				n = 0;
				lo = '0;
			end
			mask = (64'd1 << n) - 64'd1;
			carry_len = n;
			carry_bits = (n == 0) ? '0 : PEND_W'(lo & mask);
		end
		if (last) begin
			if (sent_cnt < lim) begin
				owe_digit(DIGIT_BITS'(carry_bits), lim);
			end
			while (sent_cnt < lim) begin
				owe_digit('0, lim);
			end
			carry_bits = '0;
			carry_len = 0;
			sent_cnt = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		owed_digit_t want;
		if (!arst_n) begin
			owed_q.delete();
			count_reg = cfg_t'(COUNT_RESET);
			carry_bits = '0;
			carry_len = 0;
			sent_cnt = 0;
			mismatches = 0;
			digits_checked <= 0;
		end else begin
			// Digits seen at this edge stem from earlier words, so compare before predicting.
			if (m_axis_tvalid && m_axis_tready) begin
				digits_checked <= digits_checked + 1;
				if (owed_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected digit %h last %b", $time, m_axis_tdata,
							m_axis_tlast);
					end
				end else begin
					want = owed_q.pop_front();
					if (m_axis_tdata[DIGIT_BITS-1:0] !== want.digit
							|| m_axis_tdata[TDATA_OUT_W-1:DIGIT_BITS] !== '0
							|| m_axis_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: digit exp %h act %h (tdata %h), last exp %b act %b",
								$time, want.digit, m_axis_tdata[DIGIT_BITS-1:0], m_axis_tdata,
								want.last, m_axis_tlast);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				repack_word(s_axis_tdata[WORD_BITS-1:0], s_axis_tlast);
			end
			if (cfg_we) begin
				count_reg = cfg_wdata;
			end
		end
		digits_owed <= owed_q.size();
		fail_count <= mismatches + owed_q.size();
	end

endmodule

// ===== verif/tb_limb_repack_64_to_51.sv =====
// Testbench top for limb_repack_64_to_51: drives words and backpressure, sets the digit
// count between phases and gives the verdict. Depends on lrp_pkg and lrp_digit_checker.
`timescale 1ns / 1ps

module tb_limb_repack_64_to_51;
	import lrp_pkg::*;

	// Cycles without any accepted item before the run is declared hung. The longest honest
	// quiet stretch comes from the forced receiver hold below.
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TARGET_WORDS = 410;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	cfg_t                   cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	int fail_count;
	int digits_owed;
	int digits_checked;

	int words_sent = 0;
	int numbers_sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	// Raised by the stimulus when the receiver should start its long hold.
	logic hold_req = 1'b0;

	limb_repack_64_to_51 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	lrp_digit_checker i_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.fail_count     (fail_count),
		.digits_owed    (digits_owed),
		.digits_checked (digits_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sender gaps: mostly back to back, some short pauses, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 94) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(15, 40);
	endfunction

	// Word contents lean toward the corners: zero, all ones and single set bits, which
	// show up clearly when a digit boundary is cut in the wrong place.
	function automatic word_t pick_word();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return word_t'(1) << $urandom_range(0, WORD_BITS - 1);
			end
			default: begin
				return {$urandom, $urandom};
			end
		endcase
	endfunction

	// Digit count settings: the clamped values 0 and 17..31 come up often on purpose.
	function automatic cfg_t pick_count();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				return '0;
			end
			1: begin
				return cfg_t'(1);
			end
			2: begin
				return cfg_t'(MAX_DIGITS);
			end
			3: begin
				return cfg_t'($urandom_range(MAX_DIGITS + 1, 31));
			end
			default: begin
				return cfg_t'($urandom_range(1, MAX_DIGITS));
			end
		endcase
	endfunction

	function automatic int digits_for(input cfg_t c);
		if (c == '0) begin
			return 1;
		end
		if (c > MAX_DIGITS) begin
			return MAX_DIGITS;
		end
		return c;
	endfunction

	// Offers one item and returns at the edge where it is taken. The valid stays high on
	// return, so a back-to-back item is driven in the same step without a dip.
	task automatic send_word(input word_t w, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
		if (last) begin
			numbers_sent++;
		end
	endtask

	// Waits until every predicted digit has come out, then waits further in case the
	// block is still working on words that release nothing.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (digits_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	// Only called while the block is idle.
	task automatic set_count(input cfg_t v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Receiver: random runs of ready and stalls, plus one long hold on request so that
	// the block backs up all the way to its input.
	initial begin
		int  r;
		int  len;
		logic held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					m_axis_tready <= 1'b1;
					len = $urandom_range(1, 24);
				end else if (r < 93) begin
					m_axis_tready <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					m_axis_tready <= 1'b0;
					len = $urandom_range(15, 40);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	// Hang detection: counts edges at which neither channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("limb_repack_64_to_51 verification failed");
				$finish;
			end
		end
	end

	initial begin
		int   n_numbers;
		int   len;
		int   need;
		int   r;
		logic first_phase;
		logic leave_open;
		cfg_t count;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The reset count of 15 applies first: a zero number pads out
		// entirely, an all-ones word leaves a 13-bit remainder in the second digit.
		send_word('0, 1'b1);
		send_word('1, 1'b1);
		settle();

		// Count of one: the first word already reaches the count and keeps its leftover
		// bits, later words are swallowed and the last one only clears the state.
		set_count(cfg_t'(1));
		send_word('1, 1'b0);
		send_word(pick_word(), 1'b0);
		send_word(pick_word(), 1'b1);
		settle();

		// A count of zero behaves as one.
		set_count('0);
		send_word(64'h5555_5555_5555_5555, 1'b1);
		settle();

		// All count bits set: clamped to the maximum, so a short number pads to it.
		set_count('1);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_word(64'h8000_0000_0000_0001, 1'b1);
		settle();

		// Count lowered in the middle of a number below the digits already sent:
		// the rest of that number produces nothing.
		set_count(cfg_t'(MAX_DIGITS));
		send_word(pick_word(), 1'b0);
		send_word(pick_word(), 1'b0);
		send_word(pick_word(), 1'b0);
		settle();
		set_count(cfg_t'(2));
		send_word(pick_word(), 1'b0);
		send_word(pick_word(), 1'b1);
		settle();

		// Four digits from four words: the last word has a full digit left when the
		// count runs out.
		set_count(cfg_t'(4));
		send_word({$urandom, $urandom}, 1'b0);
		send_word({$urandom, $urandom}, 1'b0);
		send_word({$urandom, $urandom}, 1'b0);
		send_word({$urandom, $urandom}, 1'b1);
		settle();

		// Just above the maximum.
		set_count(cfg_t'(MAX_DIGITS + 1));
		send_word(pick_word(), 1'b1);
		settle();

		// Random part. Each phase picks a count and sends a few numbers. Most numbers are
		// well formed, some run past the count and some are a lone word. Now and then a
		// phase ends inside a number, so the next count change lands mid-number.
		first_phase = 1'b1;
		while (words_sent < TARGET_WORDS) begin
			settle();
			if (first_phase) begin
				count = cfg_t'(MAX_DIGITS);
				n_numbers = 8;
			end else begin
				count = pick_count();
				n_numbers = $urandom_range(1, 5);
			end
			set_count(count);
			if (first_phase) begin
				hold_req = 1'b1;
			end
			need = (DIGIT_BITS * digits_for(count) + WORD_BITS - 1) / WORD_BITS;
			for (int i = 0; i < n_numbers; i++) begin
				r = $urandom_range(0, 99);
				if (first_phase || r < 70) begin
					len = first_phase ? need : $urandom_range(1, need);
				end else if (r < 88) begin
					len = need + $urandom_range(1, 4);
				end else begin
					len = 1;
				end
				leave_open = !first_phase && (i == n_numbers - 1)
					&& ($urandom_range(0, 9) == 0);
				for (int j = 0; j < len; j++) begin
					send_word(pick_word(), (j == len - 1) && !leave_open);
				end
			end
			first_phase = 1'b0;
		end

		// Close any number left open so every digit owed comes out, then drain.
		send_word(pick_word(), 1'b1);
		settle();
		repeat (8) @(posedge clk);

		$display("Sent %0d words in %0d numbers under %0d digit-count settings.",
			words_sent, numbers_sent, settings_used);
		$display("Checked %0d digits against the prediction, %0d still owed.",
			digits_checked, digits_owed);
		if (fail_count == 0) begin
			$display("limb_repack_64_to_51 verification clean");
		end else begin
			$display("limb_repack_64_to_51 verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lrp_pkg.sv
src/limb_repack_64_to_51.sv
verif/lrp_digit_checker.sv
verif/tb_limb_repack_64_to_51.sv
